### hdl/palette_nearest_colour_search_assert.svh
// Assertion macros for the palette search block
`ifndef PALETTE_NEAREST_COLOUR_SEARCH_ASSERT_SVH
`define PALETTE_NEAREST_COLOUR_SEARCH_ASSERT_SVH
// implication checked on every clock, off during reset
`define PNCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PNCS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hdl/pncs_pkg.sv
// ----------------------------------------------------------------------------
// pncs_pkg
// Shared types and constants for the palette nearest colour search.
// ----------------------------------------------------------------------------
package pncs_pkg;
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    // ceil(2^43 / 10000): exact floor divide for any 30 bit dividend
    localparam logic [29:0] YSQ_RECIP = 30'd879609303;

    typedef struct packed {
        logic       command;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  match_index;
        logic [17:0] match_distance;
    } out_word_t;

    // score request from the scan control to the scorer
    typedef struct packed {
        logic        valid;
        logic [23:0] entry;
        logic [7:0]  slot;
    } score_req_t;

    // luma times 10, before the truncating divide
    function automatic logic [17:0] luma10(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        luma10 = 18'(r) * 18'd299 + 18'(g) * 18'd587 + 18'(b) * 18'd114;
    endfunction

    // floor(x / 10) by reciprocal multiply, exact for x below 2^18
    function automatic logic [14:0] div10(input logic [17:0] x);
        logic [33:0] prod;
        prod = 34'(x) * 34'd52429;
        div10 = prod[33:19];
    endfunction
endpackage

### hdl/pncs_scorer.sv
// ----------------------------------------------------------------------------
// pncs_scorer
// Four stage score pipeline: squares and luma, luma divide, luma square,
// scaled luma term and final sum.
// ----------------------------------------------------------------------------
module pncs_scorer (
    input  logic               clk,
    input  logic               rst_n,
    input  pncs_pkg::score_req_t req,
    input  logic [7:0]         q_red,
    input  logic [7:0]         q_green,
    input  logic [7:0]         q_blue,
    input  logic [14:0]        q_luma,
    output logic               pipe_active,
    output logic               score_valid,
    output logic [7:0]         score_slot,
    output logic [18:0]        score
);
    import pncs_pkg::*;

    logic [3:0]  v_reg;
    logic [7:0]  slot1_reg, slot2_reg, slot3_reg, slot4_reg;
    logic [17:0] rgb1_reg, rgb2_reg, rgb3_reg;
    logic [17:0] l10_1_reg;
    logic [14:0] ydiff2_reg;
    logic [29:0] ysq3_reg;
    logic [18:0] score4_reg;
    logic [14:0] ye;
    logic [7:0]  dr, dg, db;
    logic [59:0] yq_prod;

    always_comb
    begin
        dr = (req.entry[23:16] > q_red)   ? req.entry[23:16] - q_red   : q_red - req.entry[23:16];
        dg = (req.entry[15:8]  > q_green) ? req.entry[15:8]  - q_green : q_green - req.entry[15:8];
        db = (req.entry[7:0]   > q_blue)  ? req.entry[7:0]   - q_blue  : q_blue - req.entry[7:0];
        ye = div10(l10_1_reg);
        yq_prod = 60'(ysq3_reg) * 60'(YSQ_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        slot1_reg  <= req.slot;
        rgb1_reg   <= 18'(dr) * 18'(dr) + 18'(dg) * 18'(dg) + 18'(db) * 18'(db);
        l10_1_reg  <= luma10(req.entry[23:16], req.entry[15:8], req.entry[7:0]);
        slot2_reg  <= slot1_reg;
        rgb2_reg   <= rgb1_reg;
        ydiff2_reg <= (ye > q_luma) ? ye - q_luma : q_luma - ye;
        slot3_reg  <= slot2_reg;
        rgb3_reg   <= rgb2_reg;
        ysq3_reg   <= 30'(ydiff2_reg) * 30'(ydiff2_reg);
        slot4_reg  <= slot3_reg;
        // top bits of the product give ysq / 10000
        score4_reg <= 19'(rgb3_reg) + 19'(yq_prod[59:43]);
    end

    assign pipe_active = |v_reg;
    assign score_valid = v_reg[3];
    assign score_slot  = slot4_reg;
    assign score       = score4_reg;
endmodule

### hdl/pncs_scan.sv
// ----------------------------------------------------------------------------
// pncs_scan
// Sequencer: palette memory, seen marks memory, sweeps, passes, best tracking.
// ----------------------------------------------------------------------------
module pncs_scan #(
    parameter int ENTRIES = 256,
    parameter int ENOUGH  = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [8:0]          palette_count,
    input  pncs_pkg::in_word_t  in_word,
    input  logic                in_go,
    output logic                busy,
    output logic                res_valid,
    output pncs_pkg::out_word_t res_word
);
    import pncs_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PASS  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [23:0] pal_mem [ENTRIES];
    logic [23:0] pal_rd_reg;
    // seen marks are cleared by a pass over all slots at the start of each query
    logic        seen_mem [ENTRIES];
    logic        seen_rd_reg;

    logic [2:0]  state_reg, state_next;
    logic [23:0] q_reg;
    logic [17:0] ql10_reg;
    logic [14:0] qy_reg;
    logic [8:0]  count_reg;
    logic [8:0]  addr_reg;       // issue address
    logic        rd_v_reg;       // read in flight
    logic [AW-1:0] rd_addr_reg;
    logic [2:0]  sweep_reg;      // 0..5
    logic [8:0]  pass_reg;
    logic [18:0] best_reg;
    logic [7:0]  best_slot_reg;
    logic        have_reg;
    logic [8:0]  scored_reg;
    logic        hit_reg;
    logic [8:0]  sv;             // sweep target value (9 bits, may be out of range)
    logic        sweep_ok;
    logic [7:0]  qc, ec;
    logic        cand;
    score_req_t  req;
    logic        sc_active;
    logic        sc_v;
    logic [7:0]  sc_slot;
    logic [18:0] sc;
    logic        seen_we;
    logic [AW-1:0] seen_wa;
    logic        seen_wd;
    logic        last_issue;
    logic        sweep_stop;
    logic        drained;
    logic        pass_end;

    always_comb
    begin
        case (sweep_reg[2:1])
            2'd0:    qc = q_reg[23:16];
            2'd1:    qc = q_reg[15:8];
            default: qc = q_reg[7:0];
        endcase
        case (sweep_reg[2:1])
            2'd0:    ec = pal_rd_reg[23:16];
            2'd1:    ec = pal_rd_reg[15:8];
            default: ec = pal_rd_reg[7:0];
        endcase
        if (!sweep_reg[0])
        begin
            sv = {1'b0, qc} - pass_reg;
            sweep_ok = pass_reg <= {1'b0, qc};
        end
        else
        begin
            sv = {1'b0, qc} + pass_reg;
            sweep_ok = (pass_reg != 9'd0) && (sv <= 9'd255);
        end
        cand = rd_v_reg && !seen_rd_reg && (ec == sv[7:0]) && !hit_reg;
        req.valid = cand && state_reg == S_SWEEP || cand && state_reg == S_DRAIN;
        req.entry = pal_rd_reg;
        req.slot  = 8'(rd_addr_reg);
        last_issue = addr_reg >= count_reg;
        sweep_stop = hit_reg || !sweep_ok || last_issue;
        drained    = !rd_v_reg && !sc_active;
        pass_end   = (have_reg && best_reg <= 19'd1) || scored_reg >= 9'(ENOUGH)
                     || pass_reg == 9'd255;
    end

    pncs_scorer u_scorer (
        .clk, .rst_n, .req,
        .q_red(q_reg[23:16]), .q_green(q_reg[15:8]), .q_blue(q_reg[7:0]),
        .q_luma(qy_reg), .pipe_active(sc_active),
        .score_valid(sc_v), .score_slot(sc_slot), .score(sc)
    );

    // the mark for a slot lands when its score leaves the pipe; a sweep reads
    // each slot once and the next sweep starts only after the pipe drains,
    // so no forwarding is needed
    always_comb
    begin
        seen_we = 1'b0;
        seen_wa = rd_addr_reg;
        seen_wd = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            seen_we = 1'b1;
            seen_wa = addr_reg[AW-1:0];
        end
        else if (sc_v && sc != 19'd0)
        begin
            seen_we = 1'b1;
            seen_wa = AW'(sc_slot);
            seen_wd = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_go && in_word.command == CMD_LOAD && {1'b0, in_word.entry_index} < 9'(ENTRIES))
        begin
            pal_mem[AW'(in_word.entry_index)] <= {in_word.red, in_word.green, in_word.blue};
        end
        pal_rd_reg  <= pal_mem[addr_reg[AW-1:0]];
        if (seen_we)
        begin
            seen_mem[seen_wa] <= seen_wd;
        end
        seen_rd_reg <= seen_mem[addr_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_go && in_word.command == CMD_MATCH) state_next = S_CLEAR;
            S_CLEAR: if (addr_reg == 9'(ENTRIES - 1)) state_next = S_SWEEP;
            S_SWEEP: if (sweep_stop) state_next = S_DRAIN;
            S_DRAIN: if (drained)
                         state_next = hit_reg ? S_DONE :
                                      (sweep_reg == 3'd5 ? S_PASS : S_SWEEP);
            S_PASS:  state_next = pass_end ? S_DONE : S_SWEEP;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            addr_reg      <= '0;
            rd_v_reg      <= 1'b0;
            rd_addr_reg   <= '0;
            sweep_reg     <= '0;
            pass_reg      <= '0;
            best_reg      <= '0;
            best_slot_reg <= '0;
            have_reg      <= 1'b0;
            scored_reg    <= '0;
            hit_reg       <= 1'b0;
            res_valid     <= 1'b0;
            res_word      <= '0;
            q_reg         <= '0;
            ql10_reg      <= '0;
            qy_reg        <= '0;
            count_reg     <= '0;
        end
        else
        begin
            res_valid <= 1'b0;
            rd_v_reg  <= 1'b0;
            state_reg <= state_next;
            if (sc_v && !hit_reg)
            begin
                if (!have_reg || sc < best_reg)
                begin
                    best_reg      <= sc;
                    best_slot_reg <= sc_slot;
                    have_reg      <= 1'b1;
                end
                if (sc == 19'd0)
                    hit_reg <= 1'b1;
                else if (scored_reg != 9'h1FF)
                    scored_reg <= scored_reg + 9'd1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    addr_reg <= '0;
                    if (in_go && in_word.command == CMD_MATCH)
                    begin
                        q_reg     <= {in_word.red, in_word.green, in_word.blue};
                        ql10_reg  <= luma10(in_word.red, in_word.green, in_word.blue);
                        count_reg <= (palette_count > 9'(ENTRIES)) ? 9'(ENTRIES)
                                                                   : palette_count;
                        sweep_reg <= '0;
                        pass_reg  <= '0;
                        best_reg  <= '0;
                        best_slot_reg <= '0;
                        have_reg  <= 1'b0;
                        scored_reg <= '0;
                        hit_reg   <= 1'b0;
                    end
                end
                S_CLEAR:
                begin
                    addr_reg <= (addr_reg == 9'(ENTRIES - 1)) ? 9'd0 : addr_reg + 9'd1;
                    qy_reg   <= div10(ql10_reg);
                end
                S_SWEEP:
                begin
                    if (!sweep_stop)
                    begin
                        rd_v_reg    <= 1'b1;
                        rd_addr_reg <= addr_reg[AW-1:0];
                        addr_reg    <= addr_reg + 9'd1;
                    end
                end
                S_DRAIN:
                begin
                    addr_reg <= '0;
                    if (drained && !hit_reg && sweep_reg != 3'd5)
                        sweep_reg <= sweep_reg + 3'd1;
                end
                S_PASS:
                begin
                    sweep_reg <= '0;
                    if (!pass_end)
                        pass_reg <= pass_reg + 9'd1;
                end
                S_DONE:
                begin
                    res_valid <= 1'b1;
                    res_word.match_index    <= best_slot_reg;
                    res_word.match_distance <= have_reg ? best_reg[17:0] : 18'd0;
                end
                default: ;
            endcase
        end
    end

    assign busy = state_reg != S_IDLE;
endmodule

### hdl/palette_nearest_colour_search.sv
// Operation: a load word writes one palette entry. A match first clears the seen marks of
// all PALETTE_ENTRIES slots, then runs passes of six sweeps, each reading up to palette_count
// entries (a sweep whose target value is out of range reads none), with a pass check after
// each pass; the result word goes through the DONE state into the output register.
// Throughput: one word at a time; no word is taken while a search runs or a result waits.
// Reset: rst_n async low; palette_count returns to 256, palette contents undefined.
// ----------------------------------------------------------------------------
// palette_nearest_colour_search
// Nearest palette entry search by per-channel sweeps over palette memory.
// ----------------------------------------------------------------------------
module palette_nearest_colour_search #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int ENOUGH_SCORED   = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [8:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  pncs_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pncs_pkg::out_word_t out_data
);
    import pncs_pkg::*;

    logic [8:0] count_reg;
    logic       busy;
    logic       res_valid;
    out_word_t  res_word;
    logic       go;
    logic       ov_reg;
    out_word_t  od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 9'd256;
        else if (cfg_we)
            count_reg <= cfg_data;
    end

    // hold input while a search runs, while a result word is on its way to the output register, or while it waits there
    assign in_ready = !busy && !ov_reg && !res_valid;
    assign go = in_valid && in_ready;

    pncs_scan #(.ENTRIES(PALETTE_ENTRIES), .ENOUGH(ENOUGH_SCORED)) u_scan (
        .clk, .rst_n, .palette_count(count_reg), .in_word(in_data), .in_go(go),
        .busy, .res_valid, .res_word
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            od_reg <= '0;
        end
        else if (res_valid)
        begin
            ov_reg <= 1'b1;
            od_reg <= res_word;
        end
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

`include "palette_nearest_colour_search_assert.svh"
    `PNCS_ASSERT_IMP(a_no_accept_busy, busy, !in_ready)
    `PNCS_ASSERT_IMP(a_res_slot_free, res_valid, !ov_reg)
    `PNCS_ASSERT_NXT(a_res_lands, res_valid, out_valid)
endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for palette_nearest_colour_search. It loads palette entries and
// sends match queries through the input channel, predicts each nearest-entry
// result, and checks the result words in order under random input and
// output idling, over a range of palette_count settings.
// ----------------------------------------------------------------------------
module tb;
    import pncs_pkg::*;

    localparam int ENTRIES   = 256;
    localparam int ENOUGH    = 25;
    localparam int TIMEOUT   = 2000000;
    localparam int LOAD_WAIT = 20;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [8:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    palette_nearest_colour_search dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // predictor state
    logic [23:0] palette_model [ENTRIES];
    bit          loaded [ENTRIES];
    int          count_model;

    in_word_t    pending_words[$];
    out_word_t   expected_matches[$];
    int          error_count;
    int          idle_cycles;
    int          cycle_no;
    bit          in_taken;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int luma(int r, int g, int b);
        return (299 * r + 587 * g + 114 * b) / 10;
    endfunction

    function automatic int sq(int a, int b);
        return (a - b) * (a - b);
    endfunction

    function automatic int colour_score(logic [23:0] e, int qr, int qg, int qb);
        int er;
        int eg;
        int eb;
        er = e[23:16];
        eg = e[15:8];
        eb = e[7:0];
        return sq(er, qr) + sq(eg, qg) + sq(eb, qb)
             + sq(luma(er, eg, eb), luma(qr, qg, qb)) / 10000;
    endfunction

    function automatic out_word_t nearest_entry(logic [7:0] r, logic [7:0] g,
                                                logic [7:0] b);
        int        q[3];
        bit        seen[ENTRIES];
        int        lim;
        int        best;
        int        slot;
        int        scored;
        int        pass_no;
        int        v;
        int        s;
        bit        have;
        bit        done;
        out_word_t res;
        q[0] = r;
        q[1] = g;
        q[2] = b;
        lim = count_model > ENTRIES ? ENTRIES : count_model;
        best = 0;
        slot = 0;
        scored = 0;
        pass_no = 0;
        have = 0;
        done = 0;
        while (!done)
        begin
            for (int c = 0; c < 3 && !done; c++)
            begin
                for (int dir = 0; dir < 2 && !done; dir++)
                begin
                    if (dir == 0)
                    begin
                        if (pass_no > q[c])
                            continue;
                        v = q[c] - pass_no;
                    end
                    else
                    begin
                        if (pass_no == 0 || q[c] + pass_no > 255)
                            continue;
                        v = q[c] + pass_no;
                    end
                    for (int i = 0; i < lim; i++)
                    begin
                        if (seen[i] || palette_model[i][(23 - 8 * c) -: 8] != v)
                            continue;
                        s = colour_score(palette_model[i], q[0], q[1], q[2]);
                        if (!have || s < best)
                        begin
                            best = s;
                            slot = i;
                            have = 1;
                        end
                        if (s == 0)
                        begin
                            done = 1;
                            break;
                        end
                        scored++;
                        seen[i] = 1;
                    end
                end
            end
            if (done)
                break;
            if (have && best <= 1)
                break;
            if (scored >= ENOUGH)
                break;
            pass_no++;
            if (pass_no > 255)
                break;
        end
        res.match_index = slot[7:0];
        res.match_distance = have ? best[17:0] : 18'd0;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic bit quiet_stretch();
        return (cycle_no % 4000) >= 2800;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_words.size() > 0 &&
                    (quiet_stretch() || $urandom_range(99) >= 10))
                begin
                    in_data <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= quiet_stretch() || $urandom_range(99) >= 10;
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        out_word_t want;
        in_taken = in_valid && in_ready;
        if (rst_n)
        begin
            cycle_no++;
            idle_cycles++;
            if (in_taken)
            begin
                idle_cycles = 0;
                if (in_data.command == CMD_LOAD)
                begin
                    palette_model[in_data.entry_index] =
                        {in_data.red, in_data.green, in_data.blue};
                end
                else
                    expected_matches.push_back(
                        nearest_entry(in_data.red, in_data.green, in_data.blue));
            end
            if (out_valid && out_ready)
            begin
                idle_cycles = 0;
                if (expected_matches.size() == 0)
                    report_mismatch("unexpected word", 1, 0);
                else
                begin
                    want = expected_matches.pop_front();
                    if (out_data.match_index !== want.match_index)
                        report_mismatch("match_index", out_data.match_index,
                                        want.match_index);
                    if (out_data.match_distance !== want.match_distance)
                        report_mismatch("match_distance", out_data.match_distance,
                                        want.match_distance);
                end
            end
            if (idle_cycles >= TIMEOUT)
            begin
                $display("watchdog expired at %0t", $time);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push_load(int idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        in_word_t w;
        w.command = CMD_LOAD;
        w.entry_index = idx[7:0];
        w.red = r;
        w.green = g;
        w.blue = b;
        pending_words.push_back(w);
        loaded[idx] = 1;
    endtask

    task automatic push_match(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        in_word_t w;
        w.command = CMD_MATCH;
        w.entry_index = 8'($urandom_range(255));
        w.red = r;
        w.green = g;
        w.blue = b;
        pending_words.push_back(w);
    endtask

    function automatic logic [7:0] near_value(int base);
        int v;
        v = base + $urandom_range(6) - 3;
        return v < 0 ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
    endfunction

    task automatic drain();
        wait (pending_words.size() == 0 && !in_valid && expected_matches.size() == 0);
        repeat (LOAD_WAIT) @(posedge clk);
    endtask

    task automatic write_count(int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value[8:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        count_model = value;
    endtask

    task automatic random_phase(int words, int lim);
        int k;
        for (int n = 0; n < words; n++)
        begin
            if ($urandom_range(99) < 35)
                push_load($urandom_range(255), 8'($urandom), 8'($urandom), 8'($urandom));
            else if (lim > 0 && $urandom_range(1))
            begin
                // query close to a live entry
                k = $urandom_range(lim - 1);
                push_match(near_value(palette_model[k][23:16]),
                           near_value(palette_model[k][15:8]),
                           near_value(palette_model[k][7:0]));
            end
            else
                push_match(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int counts[4] = '{1, 2, 8, 40};
        int lim;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        in_taken = 0;
        error_count = 0;
        idle_cycles = 0;
        cycle_no = 0;
        count_model = 256;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty palette: nothing scored
        write_count(0);
        push_load(255, 8'hff, 8'hff, 8'hff);
        push_match(8'h00, 8'h00, 8'h00);
        push_match(8'hff, 8'hff, 8'hff);
        drain();

        // single black entry: exact hit, then the far corner and another miss
        write_count(1);
        push_load(0, 8'h00, 8'h00, 8'h00);
        push_match(8'h00, 8'h00, 8'h00);
        push_match(8'hff, 8'hff, 8'hff);
        push_match(8'hff, 8'h00, 8'h80);
        drain();

        // ties and a near miss of distance one
        write_count(4);
        push_load(1, 8'hff, 8'hff, 8'hff);
        push_load(2, 8'h10, 8'h20, 8'h30);
        push_load(3, 8'h10, 8'h20, 8'h30);
        push_match(8'h10, 8'h20, 8'h30);
        push_match(8'h11, 8'h20, 8'h30);
        push_match(8'hfe, 8'hff, 8'hff);
        push_match(8'h80, 8'h80, 8'h80);
        push_match(8'h00, 8'hff, 8'h00);
        drain();

        foreach (counts[p])
        begin
            lim = counts[p] > ENTRIES ? ENTRIES : counts[p];
            for (int i = 0; i < lim; i++)
                if (!loaded[i])
                    push_load(i, 8'($urandom), 8'($urandom), 8'($urandom));
            drain();
            write_count(counts[p]);
            random_phase(p < 2 ? 15 : 30, lim);
            drain();
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/pncs_pkg.sv
hdl/pncs_scorer.sv
hdl/pncs_scan.sv
hdl/palette_nearest_colour_search.sv
dv/tb.sv
